FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the random-replacement tag list.
// No dependencies; define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/rrtl_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// random-replacement tag list. No dependencies.
package rrtl_pkg;

  // List geometry.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int OFFSET_W = 48;
  localparam int POS_W    = 4;
  localparam int MAX_W    = 5;
  localparam int SEED_W   = 16;
  localparam int CMP_W    = (CNT_W > MAX_W) ? CNT_W : MAX_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Replacement LFSR and its remainder unit.
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;
  localparam logic [MAX_W-1:0]  MAX_RESET  = 5'd16;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = SEED_W / DIV_BITS;
  localparam int DSTEP_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Register port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_RANDOM_SEED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic div_step;
    logic commit;
    logic load_out;
  } rrtl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            evict_needed;
    logic            out_free;
  } rrtl_status_t;

endpackage

FILE: rtl/core/random_replacement_tag_list.sv
// Top level of the random-replacement tag list: register port, controller
// and datapath. Depends on rrtl_pkg, rrtl_ctrl, rrtl_dp and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  op, block_offset
//   out       output     out_valid/out_ready  hit, position, evicted,
//                                             evicted_offset, entry_count
//   register  input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A lookup, a clear or an insert into a list with room runs its execute step
// and loads its result in the finish step; the next beat waits until idle.
// An evicting insert runs 4 steps of the remainder unit, which retires 4
// dividend bits a cycle, and one commit step before its finish step.
// Reset empties the list and loads the LFSR with 1; no clearing pass is needed.
// A result waits in the output register while the next beat is accepted; the
// block stalls in its last step only when that register is still full.
`include "assert_macros.svh"
module random_replacement_tag_list
  import rrtl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [OFFSET_W-1:0] block_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [POS_W-1:0]    position,
  output logic                evicted,
  output logic [OFFSET_W-1:0] evicted_offset,
  output logic [MAX_W-1:0]    entry_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [MAX_W-1:0]  max_entries;
  logic [SEED_W-1:0] random_seed;
  logic              reg_write;
  rrtl_cmd_t         cmd;
  rrtl_status_t      status;

  // Register port: zero wait states, registers decoded by the word address.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_RESET;
      random_seed <= SEED_RESET;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_MAX_ENTRIES: max_entries <= pwdata[MAX_W-1:0];
        REG_RANDOM_SEED: random_seed <= pwdata[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[2])
      REG_MAX_ENTRIES: prdata = DATA_W'(max_entries);
      REG_RANDOM_SEED: prdata = DATA_W'(random_seed);
      default:         prdata = '0;
    endcase
  end

  // Controller and datapath.
  rrtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rrtl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .max_entries    (max_entries),
    .random_seed    (random_seed),
    .op             (op),
    .block_offset   (block_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .position       (position),
    .evicted        (evicted),
    .evicted_offset (evicted_offset),
    .entry_count    (entry_count)
  );

  // The block is busy in the cycle after it takes a beat.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // A waiting result is never overwritten.
  `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst, cmd.load_out, status.out_free)
  // The evicting write happens only when the list is at its limit.
  `ASSERT_IMPLIES(a_commit_only_on_evict, clk, rst, cmd.commit, status.evict_needed)

endmodule

FILE: rtl/core/rrtl_ctrl.sv
// Controller state machine of the random-replacement tag list.
// Depends on rrtl_pkg for the command and status types.
module rrtl_ctrl
  import rrtl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rrtl_status_t status,
  output rrtl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [DSTEP_W-1:0] step;
  logic [DSTEP_W-1:0] step_next;

  // A new beat is taken only between operations.
  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.op == OP_INSERT && status.evict_needed) begin
          state_next = S_DIV;
          step_next  = '0;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DSTEP_W'(DIV_STEPS - 1)) begin
          state_next = S_COMMIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

FILE: rtl/core/rrtl_dp.sv
// Datapath of the random-replacement tag list: entry registers, tag compare,
// replacement LFSR, remainder unit and result registers.
// Depends on rrtl_pkg for constants, codes and the command and status types.
module rrtl_dp
  import rrtl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rrtl_cmd_t           cmd,
  output rrtl_status_t        status,
  input  logic [MAX_W-1:0]    max_entries,
  input  logic [SEED_W-1:0]   random_seed,
  input  logic [OP_W-1:0]     op,
  input  logic [OFFSET_W-1:0] block_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [POS_W-1:0]    position,
  output logic                evicted,
  output logic [OFFSET_W-1:0] evicted_offset,
  output logic [MAX_W-1:0]    entry_count
);

  // Latched input beat.
  logic [OP_W-1:0]     op_q;
  logic [OFFSET_W-1:0] off_q;

  // List state.
  logic [OFFSET_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]    count;
  logic [SEED_W-1:0]   lfsr;

  // Remainder unit.
  logic [SEED_W-1:0]   div_q;
  logic [CNT_W-1:0]    div_r;
  logic [SEED_W-1:0]   div_q_next;
  logic [CNT_W-1:0]    div_r_next;
  logic [CNT_W:0]      div_trial;

  // Staged result.
  logic                res_hit;
  logic [IDX_W-1:0]    res_pos;
  logic                res_ev;
  logic [OFFSET_W-1:0] res_evoff;

  // Combinational helpers.
  logic [CMP_W-1:0]    max_ext;
  logic [CMP_W-1:0]    limit;
  logic                evict_needed;
  logic [SEED_W-1:0]   lfsr_adv;
  logic [SEED_W-1:0]   seed_fixed;
  logic                look_hit;
  logic [IDX_W-1:0]    look_pos;
  logic                do_insert;
  logic [IDX_W-1:0]    ins_idx;

  // Effective limit: zero acts as one, anything above the capacity as the capacity.
  always_comb begin
    max_ext = CMP_W'(max_entries);
    if (max_ext == '0) begin
      limit = CMP_W'(1);
    end else if (max_ext > CMP_W'(CAPACITY)) begin
      limit = CMP_W'(CAPACITY);
    end else begin
      limit = max_ext;
    end
  end

  assign evict_needed = (count != '0) && (CMP_W'(count) >= limit);

  assign status.op           = op_q;
  assign status.evict_needed = evict_needed;
  assign status.out_free     = !out_valid || out_ready;

  // Galois LFSR step, shifting right; a zero seed is loaded as one.
  assign lfsr_adv   = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign seed_fixed = (random_seed == '0) ? SEED_RESET : random_seed;

  // Parallel tag compare; the lowest matching position wins.
  always_comb begin
    look_hit = 1'b0;
    look_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count && entries[i] == off_q) begin
        look_hit = 1'b1;
        look_pos = IDX_W'(i);
      end
    end
  end

  // Restoring remainder of the LFSR value by the count, several bits a cycle.
  always_comb begin
    div_q_next = div_q;
    div_r_next = div_r;
    div_trial  = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      div_trial  = {div_r_next, div_q_next[SEED_W-1]};
      div_q_next = {div_q_next[SEED_W-2:0], 1'b0};
      if (div_trial >= {1'b0, count}) begin
        div_trial = div_trial - {1'b0, count};
      end
      div_r_next = div_trial[CNT_W-1:0];
    end
  end

  // An insert writes the whole list at once. Positions before the removed
  // index move back by one; with no removal every position moves back.
  assign do_insert = (cmd.exec && op_q == OP_INSERT && !evict_needed) || cmd.commit;
  assign ins_idx   = cmd.commit ? div_r[IDX_W-1:0] : '1;

  always_ff @(posedge clk) begin
    if (do_insert) begin
      entries[0] <= off_q;
      for (int i = 1; i < CAPACITY; i++) begin
        if (IDX_W'(i - 1) < ins_idx) begin
          entries[i] <= entries[i-1];
        end
      end
    end
  end

  // Input beat latch, remainder unit and staged result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= op;
      off_q <= block_offset;
    end
    if (cmd.exec) begin
      res_hit   <= (op_q == OP_LOOKUP) && look_hit;
      res_pos   <= (op_q == OP_LOOKUP && look_hit) ? look_pos : '0;
      res_ev    <= 1'b0;
      res_evoff <= '0;
      div_q     <= lfsr_adv;
      div_r     <= '0;
    end
    if (cmd.div_step) begin
      div_q <= div_q_next;
      div_r <= div_r_next;
    end
    if (cmd.commit) begin
      res_ev    <= 1'b1;
      res_evoff <= entries[div_r[IDX_W-1:0]];
    end
  end

  // Count and LFSR.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lfsr  <= SEED_RESET;
    end else if (cmd.exec) begin
      if (op_q == OP_CLEAR) begin
        count <= '0;
        lfsr  <= seed_fixed;
      end else if (op_q == OP_INSERT) begin
        if (evict_needed) begin
          lfsr <= lfsr_adv;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Output register; a finished result may wait here while the next beat enters.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit            <= res_hit;
      position       <= POS_W'(res_pos);
      evicted        <= res_ev;
      evicted_offset <= res_evoff;
      entry_count    <= MAX_W'(count);
    end
  end

endmodule
